// File: hw/rtl/rnorm_pkg.sv
`default_nettype none

package rnorm_pkg;

   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] num_in;
      logic signed [DATA_WIDTH-1:0] den_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] num_out;
      logic        [DATA_WIDTH-2:0] den_out;
      logic                         den_zero;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/rational_normalizer.sv
`default_nettype none

// Channel  Direction  Ports                              Item
// req      in         req_valid, req_ready, req_data     numerator and denominator
// rsp      out        rsp_valid, rsp_ready, rsp_data     reduced fraction and zero flag
//
// Each item runs through one restoring divider. Euclid's loop takes one division
// per remainder step, then two more divisions reduce the magnitudes. A zero
// numerator skips the divisions. Reset is synchronous and needs no sweep.
// A new item is taken while the previous result still waits on rsp_ready.

module rational_normalizer import rnorm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int W = DATA_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_NDIV = 3'd3;
   localparam logic [2:0] ST_DDIV = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_ff, out_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] nmag_ff, nmag_in;
   logic [W-1:0] dmag_ff, dmag_in;
   logic [W-1:0] rn_ff, rn_in;
   logic [W-1:0] rd_ff, rd_in;
   logic         neg_ff, neg_in;
   logic         dz_ff, dz_in;
   logic         sel_a_ff, sel_a_in;

   logic [W-1:0] n_raw, d_raw, n_mag, d_mag;
   logic [W-1:0] rn_sat, rd_sat, gcd;
   logic         div_start, div_done;
   logic [W-1:0] div_dividend, div_divisor, div_quo, div_rem;

   rnorm_div #(
      .WIDTH (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      n_raw  = req_data.num_in;
      d_raw  = req_data.den_in;
      n_mag  = n_raw[W-1] ? (~n_raw + W'(1)) : n_raw;
      d_mag  = d_raw[W-1] ? (~d_raw + W'(1)) : d_raw;
      gcd    = a_ff | b_ff;
      rn_sat = rn_ff[W-1] ? {1'b0, {(W-1){1'b1}}} : rn_ff;
      rd_sat = rd_ff[W-1] ? {1'b0, {(W-1){1'b1}}} : rd_ff;

      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      sel_a_in     = sel_a_ff;
      div_start    = 1'b0;
      div_dividend = nmag_ff;
      div_divisor  = a_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               nmag_in = n_mag;
               dmag_in = d_mag;
               a_in    = n_mag;
               b_in    = d_mag;
               neg_in  = n_raw[W-1] != d_raw[W-1];
               dz_in   = d_mag == '0;
               if (n_mag == '0) begin
                  rn_in    = '0;
                  rd_in    = W'(1);
                  neg_in   = 1'b0;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               a_in         = gcd;
               div_start    = 1'b1;
               div_dividend = nmag_ff;
               div_divisor  = gcd;
               state_in     = ST_NDIV;
            end else begin
               sel_a_in     = a_ff > b_ff;
               div_start    = 1'b1;
               div_dividend = (a_ff > b_ff) ? a_ff : b_ff;
               div_divisor  = (a_ff > b_ff) ? b_ff : a_ff;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               if (sel_a_ff) begin
                  a_in = div_rem;
               end else begin
                  b_in = div_rem;
               end
               state_in = ST_GCD;
            end
         end
         ST_NDIV: begin
            if (div_done) begin
               rn_in        = div_quo;
               div_start    = 1'b1;
               div_dividend = dmag_ff;
               div_divisor  = a_ff;
               state_in     = ST_DDIV;
            end
         end
         ST_DDIV: begin
            if (div_done) begin
               rd_in    = div_quo;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in.num_out  = neg_ff ? (~rn_sat + W'(1)) : rn_sat;
               out_in.den_out  = rd_sat[W-2:0];
               out_in.den_zero = dz_ff;
               out_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      nmag_ff  <= nmag_in;
      dmag_ff  <= dmag_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      neg_ff   <= neg_in;
      dz_ff    <= dz_in;
      sel_a_ff <= sel_a_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A zero numerator always leaves as 0/1.
   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.num_out == '0 |-> rsp_data.den_out == (W-1)'(1))
      else $error("zero numerator without unit denominator");

   // A zero denominator with a nonzero numerator gives plus or minus one over zero.
   a_den_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.den_zero && rsp_data.num_out != '0
      |-> rsp_data.den_out == '0 &&
          (rsp_data.num_out == W'(1) || rsp_data.num_out == {W{1'b1}}))
      else $error("zero denominator result malformed");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_MOD || state_ff == ST_NDIV || state_ff == ST_DDIV)
      else $error("divider finished outside a division state");

   // The divider is never started while the previous result is still expected.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("divider restarted too early");

endmodule

`default_nettype wire

// File: hw/rtl/rnorm_div.sv
`default_nettype none

module rnorm_div import rnorm_pkg::*; #(
   parameter int WIDTH = DATA_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = !diff[WIDTH];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: bench/rational_normalizer_test.sv
`timescale 1ns / 100ps

module rational_normalizer_test;
   import rnorm_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_CYCLES = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 310;
   localparam int STREAM_ITEMS = 60;
   localparam int STALL_ITEMS = 40;
   localparam int STALL_CYCLES = 2500;
   localparam logic [DATA_WIDTH-1:0] MAG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] FIB_46 = 1836311903;
   localparam logic [DATA_WIDTH-1:0] FIB_45 = 1134903170;

   typedef struct {
      req_type fraction;
      rsp_type reduced;
   } pending_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic streaming = 1'b0;
   logic rsp_hold = 1'b0;
   int rsp_wait = 0;
   int failures = 0;
   int unsigned cycle_count = 0;
   pending_type pending_fractions[$];

   rational_normalizer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic rsp_type reduce_fraction(req_type f);
      logic [DATA_WIDTH-1:0] n_raw, d_raw, n_mag, d_mag, a, b, g, rn, rd;
      logic n_neg, d_neg;
      rsp_type r;
      n_raw = f.num_in;
      d_raw = f.den_in;
      n_neg = n_raw[DATA_WIDTH-1];
      d_neg = d_raw[DATA_WIDTH-1];
      n_mag = n_neg ? (~n_raw + 1'b1) : n_raw;
      d_mag = d_neg ? (~d_raw + 1'b1) : d_raw;
      r.den_zero = (d_mag == '0);
      if (n_mag == '0) begin
         r.num_out = '0;
         r.den_out = (DATA_WIDTH-1)'(1);
         return r;
      end
      a = n_mag;
      b = d_mag;
      while (a != '0 && b != '0) begin
         if (a > b)
            a = a % b;
         else
            b = b % a;
      end
      g = a + b;
      rn = n_mag / g;
      rd = d_mag / g;
      if (rn > MAG_MAX)
         rn = MAG_MAX;
      if (rd > MAG_MAX)
         rd = MAG_MAX;
      r.num_out = (n_neg != d_neg) ? (~rn + 1'b1) : rn;
      r.den_out = rd[DATA_WIDTH-2:0];
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] draw_magnitude();
      logic [DATA_WIDTH-1:0] m;
      case ($urandom_range(0, 9))
         0: m = '0;
         1, 2: m = $urandom_range(1, 100);
         3, 4: m = $urandom_range(1, MAG_MAX);
         5: m = ($urandom_range(0, 1) == 1) ? (MAG_MAX - $urandom_range(0, 3))
                                            : (1 << $urandom_range(0, DATA_WIDTH - 2));
         default: m = $urandom_range(1, 65535);
      endcase
      return m;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] apply_sign(logic [DATA_WIDTH-1:0] mag);
      return ($urandom_range(0, 1) == 1) ? (~mag + 1'b1) : mag;
   endfunction

   task automatic send_fraction(input logic [DATA_WIDTH-1:0] num,
                                input logic [DATA_WIDTH-1:0] den);
      int gap;
      req_type item;
      pending_type entry;
      gap = streaming ? 0 : $urandom_range(0, 3);
      item.num_in = num;
      item.den_in = den;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      entry.fraction = item;
      entry.reduced = reduce_fraction(item);
      pending_fractions.push_back(entry);
   endtask

   task automatic send_random_fraction();
      logic [DATA_WIDTH-1:0] n_mag, d_mag, k;
      if ($urandom_range(0, 3) == 0) begin
         // Shared factor so that the reduction has real work to do.
         k = $urandom_range(1, 46000);
         n_mag = $urandom_range(0, 46000) * k;
         d_mag = $urandom_range(0, 46000) * k;
      end else begin
         n_mag = draw_magnitude();
         d_mag = draw_magnitude();
      end
      send_fraction(apply_sign(n_mag), apply_sign(d_mag));
   endtask

   task automatic hold_responses(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   always @(posedge clock) begin
      pending_type entry;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fractions.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("unexpected item: %0d/%0d zero %0b", rsp_data.num_out,
                        rsp_data.den_out, rsp_data.den_zero);
            failures++;
         end else begin
            entry = pending_fractions.pop_front();
            if (rsp_data.num_out !== entry.reduced.num_out ||
                rsp_data.den_out !== entry.reduced.den_out ||
                rsp_data.den_zero !== entry.reduced.den_zero) begin
               if (failures < MAX_REPORTS)
                  $display("mismatch for %0d/%0d: expected %0d/%0d zero %0b, got %0d/%0d zero %0b",
                           entry.fraction.num_in, entry.fraction.den_in,
                           entry.reduced.num_out, entry.reduced.den_out,
                           entry.reduced.den_zero, rsp_data.num_out,
                           rsp_data.den_out, rsp_data.den_zero);
               failures++;
            end
         end
         rsp_wait = streaming ? 0 : $urandom_range(0, 3);
      end
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_directed();
      send_fraction(0, 0);
      send_fraction(0, 5);
      send_fraction(0, -7);
      send_fraction(0, MAG_MAX);
      send_fraction(5, 0);
      send_fraction(-5, 0);
      send_fraction(1, 0);
      send_fraction(1, 1);
      send_fraction(-1, 1);
      send_fraction(MAG_MAX, MAG_MAX);
      send_fraction(MAG_MAX, -MAG_MAX);
      send_fraction(-MAG_MAX, MAG_MAX);
      send_fraction(-MAG_MAX, -MAG_MAX);
      send_fraction(MAG_MAX, 1);
      send_fraction(1, -MAG_MAX);
      send_fraction(MAG_MAX, 2);
      send_fraction(6, 4);
      send_fraction(-6, 4);
      send_fraction(6, -4);
      send_fraction(-6, -4);
      // Consecutive Fibonacci numbers give the longest remainder chain.
      send_fraction(FIB_46, FIB_45);
      send_fraction(-FIB_45, FIB_46);
      send_fraction(1 << 30, 1 << 29);
      send_fraction(3 << 29, -(1 << 30));
   endtask

   task automatic test_streaming();
      streaming <= 1'b1;
      repeat (STREAM_ITEMS) send_random_fraction();
      streaming <= 1'b0;
   endtask

   task automatic test_receiver_stall();
      fork
         hold_responses(STALL_CYCLES);
         repeat (STALL_ITEMS) send_random_fraction();
      join
   endtask

   task automatic test_random();
      repeat (RANDOM_ITEMS) send_random_fraction();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_streaming();
      test_receiver_stall();
      test_random();
      req_valid <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rnorm_pkg.sv
hw/rtl/rnorm_div.sv
hw/rtl/rational_normalizer.sv
bench/rational_normalizer_test.sv
